### hdl/irpd_pkg.sv
package irpd_pkg;

    localparam int CNT_W   = 24;
    localparam int IDX_W   = 6;
    localparam int CMD_W   = 8;
    localparam int CFG_A_W = 3;

    // recorded intervals per frame, later edges are ignored
    localparam logic [IDX_W-1:0] MAX_EDGES = 6'd50;

    localparam logic [CFG_A_W-1:0] REG_TIMEOUT   = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_LEAD_MIN  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_LEAD_MAX  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_ONE_MIN   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_ONE_MAX   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_FIRST_BIT = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_ON_CODE   = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_OFF_CODE  = 3'd7;

    localparam logic [CNT_W-1:0] RST_TIMEOUT   = 24'd1000000;
    localparam logic [CNT_W-1:0] RST_LEAD_MIN  = 24'd10000;
    localparam logic [CNT_W-1:0] RST_LEAD_MAX  = 24'd14000;
    localparam logic [CNT_W-1:0] RST_ONE_MIN   = 24'd2000;
    localparam logic [CNT_W-1:0] RST_ONE_MAX   = 24'd2300;
    localparam logic [IDX_W-1:0] RST_FIRST_BIT = 6'd17;
    localparam logic [CMD_W-1:0] RST_ON_CODE   = 8'd69;
    localparam logic [CMD_W-1:0] RST_OFF_CODE  = 8'd71;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             frame_valid;
        logic             led_level;
    } result_t;

endpackage

### hdl/ir_pulse_distance_decoder_top.sv
// channel  | dir | tdata bits (lsb up)                          | handshake
// s_axis   | in  | [0] edge_req, [7:1] zero                     | s_tvalid / s_tready
// m_axis   | out | [7:0] command, [8] frame_valid, [9] led_level | m_tvalid / m_tready
// cfg      | in  | cfg_index selects register, cfg_wdata value  | cfg_wr_en, no wait
//
// one word per cycle while the output register is free: a tick is registered, then decoded against the
// frame state, a result word lands in the output register at frame timeout
// the result word is offered from the output register once the frame-ending tick leaves the input register
// a tick that ends a frame waits in the input register while the output word is stalled
// rst_n clears frame state, led level, command bits and loads register defaults
module ir_pulse_distance_decoder_top
    import irpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [0] edge_req
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [7:0] command, [8] frame_valid, [9] led_level
    input  logic               cfg_wr_en,
    input  logic [CFG_A_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]   cfg_wdata
);

    // configuration registers
    logic [CNT_W-1:0] timeout_reg, lead_min_reg, lead_max_reg, one_min_reg, one_max_reg;
    logic [IDX_W-1:0] first_bit_reg;
    logic [CMD_W-1:0] on_code_reg, off_code_reg;

    // input stage
    logic in_valid_reg;
    logic in_edge_reg;

    // frame state
    logic             active_reg, active_next;
    logic [CNT_W-1:0] tick_reg, tick_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             leader_ok_reg, leader_ok_next;
    logic [CMD_W-1:0] bits_reg, bits_next;
    logic             led_reg, led_next;

    // output stage
    logic    out_valid_reg;
    result_t out_reg;
    result_t res_next;

    logic             out_free;
    logic             advance;
    logic             finish;
    logic [CNT_W:0]   elapsed;
    logic [IDX_W-1:0] pos;
    logic             bit_slot;
    logic             bit_one;
    logic             valid_f;
    logic [CMD_W-1:0] cmd_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= RST_TIMEOUT;
            lead_min_reg  <= RST_LEAD_MIN;
            lead_max_reg  <= RST_LEAD_MAX;
            one_min_reg   <= RST_ONE_MIN;
            one_max_reg   <= RST_ONE_MAX;
            first_bit_reg <= RST_FIRST_BIT;
            on_code_reg   <= RST_ON_CODE;
            off_code_reg  <= RST_OFF_CODE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TIMEOUT:   timeout_reg   <= cfg_wdata;
                REG_LEAD_MIN:  lead_min_reg  <= cfg_wdata;
                REG_LEAD_MAX:  lead_max_reg  <= cfg_wdata;
                REG_ONE_MIN:   one_min_reg   <= cfg_wdata;
                REG_ONE_MAX:   one_max_reg   <= cfg_wdata;
                REG_FIRST_BIT: first_bit_reg <= cfg_wdata[IDX_W-1:0];
                REG_ON_CODE:   on_code_reg   <= cfg_wdata[CMD_W-1:0];
                REG_OFF_CODE:  off_code_reg  <= cfg_wdata[CMD_W-1:0];
                default:       ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign elapsed  = {1'b0, tick_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign finish   = active_reg && (elapsed >= {1'b0, timeout_reg});
    // a frame-ending tick needs room in the output register
    assign advance  = in_valid_reg && (!finish || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign pos      = idx_reg - first_bit_reg;
    assign bit_slot = (idx_reg >= first_bit_reg) && (pos < IDX_W'(CMD_W));
    assign bit_one  = (elapsed >= {1'b0, one_min_reg}) && (elapsed <= {1'b0, one_max_reg});

    // frame end: command and validity
    always_comb
    begin
        cmd_f   = bits_reg;
        valid_f = leader_ok_reg;
        if (idx_reg == '0)
        begin
            valid_f = (lead_min_reg == '0);
            if (first_bit_reg == '0)
            begin
                cmd_f[0] = (one_min_reg == '0);
            end
        end
    end

    always_comb
    begin
        active_next    = active_reg;
        tick_next      = tick_reg;
        idx_next       = idx_reg;
        leader_ok_next = leader_ok_reg;
        bits_next      = bits_reg;
        led_next       = led_reg;
        res_next       = '0;

        if (finish)
        begin
            if (valid_f)
            begin
                if (cmd_f == on_code_reg)
                begin
                    led_next = 1'b1;
                end
                else if (cmd_f == off_code_reg)
                begin
                    led_next = 1'b0;
                end
            end
            res_next.command     = valid_f ? cmd_f : '0;
            res_next.frame_valid = valid_f;
            res_next.led_level   = led_next;
            active_next    = 1'b0;
            tick_next      = '0;
            idx_next       = '0;
            leader_ok_next = 1'b0;
        end
        else if (active_reg && in_edge_reg)
        begin
            tick_next = '0;
            if (idx_reg < MAX_EDGES)
            begin
                if (idx_reg == '0)
                begin
                    leader_ok_next = (elapsed >= {1'b0, lead_min_reg})
                                  && (elapsed <= {1'b0, lead_max_reg});
                end
                if (bit_slot)
                begin
                    bits_next[pos[2:0]] = bit_one;
                end
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (active_reg)
        begin
            // saturating count of ticks since the last edge
            if (tick_reg != {CNT_W{1'b1}})
            begin
                tick_next = tick_reg + 1'b1;
            end
        end

        // an edge outside a frame, or on the timeout tick, opens a new frame
        if (in_edge_reg && (!active_reg || finish))
        begin
            active_next    = 1'b1;
            tick_next      = '0;
            idx_next       = '0;
            leader_ok_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            active_reg    <= 1'b0;
            tick_reg      <= '0;
            idx_reg       <= '0;
            leader_ok_reg <= 1'b0;
            bits_reg      <= '0;
            led_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                active_reg    <= active_next;
                tick_reg      <= tick_next;
                idx_reg       <= idx_next;
                leader_ok_reg <= leader_ok_next;
                bits_reg      <= bits_next;
                led_reg       <= led_next;
            end
            if (advance && finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_edge_reg <= s_tdata[0];
        end
        if (advance && finish)
        begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.led_level, out_reg.frame_valid, out_reg.command};

endmodule

### tb/sv/ir_pulse_distance_decoder_top_test.sv
`timescale 1ns / 1ps

module ir_pulse_distance_decoder_top_test;
    import irpd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = 8'd0;   // [0] edge_req, [7:1] zero
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [15:0]        m_tdata;            // [7:0] command, [8] frame_valid, [9] led_level
    logic               cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]   cfg_wdata = '0;

    ir_pulse_distance_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // decoder settings as the predictor sees them
    logic [CNT_W-1:0] cfg_tmo     = RST_TIMEOUT;
    logic [CNT_W-1:0] cfg_lead_lo = RST_LEAD_MIN;
    logic [CNT_W-1:0] cfg_lead_hi = RST_LEAD_MAX;
    logic [CNT_W-1:0] cfg_one_lo  = RST_ONE_MIN;
    logic [CNT_W-1:0] cfg_one_hi  = RST_ONE_MAX;
    logic [IDX_W-1:0] cfg_first   = RST_FIRST_BIT;
    logic [CMD_W-1:0] cfg_on      = RST_ON_CODE;
    logic [CMD_W-1:0] cfg_off     = RST_OFF_CODE;

    // predicted frame state
    logic             in_frame  = 1'b0;
    logic [CNT_W-1:0] gap_cnt   = '0;
    logic [IDX_W-1:0] iv_idx    = '0;
    logic             lead_good = 1'b0;
    logic [CMD_W-1:0] cmd_bits  = '0;
    logic             led_on    = 1'b0;

    bit      ticks_to_send[$];
    result_t due_results[$];
    result_t want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left    = 0;
    int mismatches    = 0;
    int words_seen    = 0;
    int ticks_sent    = 0;
    int ticks_queued  = 0;
    int frames_queued = 0;
    int settings_used = 0;
    int cycle_cnt     = 0;

    function automatic logic in_range(input logic [CNT_W:0] v,
                                      input logic [CNT_W-1:0] lo, input logic [CNT_W-1:0] hi);
        return (v >= {1'b0, lo}) && (v <= {1'b0, hi});
    endfunction

    // advance the predicted decoder by one tick, queue a result at frame end
    task automatic decode_tick(input logic pulse);
        logic [CNT_W:0]   elapsed;
        logic [CMD_W-1:0] cmd;
        logic             valid;
        int               pos;
        if (in_frame) begin
            elapsed = {1'b0, gap_cnt} + 1'b1;
            if (elapsed >= {1'b0, cfg_tmo}) begin
                cmd = cmd_bits;
                if (iv_idx == 0) begin
                    // frame closed before any interval was measured
                    valid = (cfg_lead_lo == 0);
                    if (cfg_first == 0)
                        cmd[0] = (cfg_one_lo == 0);
                end else begin
                    valid = lead_good;
                end
                if (!valid)
                    cmd = '0;
                else if (cmd == cfg_on)
                    led_on = 1'b1;
                else if (cmd == cfg_off)
                    led_on = 1'b0;
                due_results.push_back('{command: cmd, frame_valid: valid, led_level: led_on});
                in_frame  = 1'b0;
                gap_cnt   = '0;
                iv_idx    = '0;
                lead_good = 1'b0;
            end else if (pulse) begin
                if (iv_idx < MAX_EDGES) begin
                    if (iv_idx == 0)
                        lead_good = in_range(elapsed, cfg_lead_lo, cfg_lead_hi);
                    if (iv_idx >= cfg_first) begin
                        pos = int'(iv_idx) - int'(cfg_first);
                        if (pos < 8)
                            cmd_bits[pos] = in_range(elapsed, cfg_one_lo, cfg_one_hi);
                    end
                    iv_idx = iv_idx + 1'b1;
                end
                gap_cnt = '0;
                return;
            end else begin
                if (gap_cnt != '1)
                    gap_cnt = gap_cnt + 1'b1;
                return;
            end
        end
        if (pulse) begin
            in_frame  = 1'b1;
            gap_cnt   = '0;
            iv_idx    = '0;
            lead_good = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch on result word %0d: %s", words_seen, what);
    endtask

    // sender
    always @(posedge clk) begin
        if (s_tvalid && s_tready) begin
            decode_tick(s_tdata[0]);
            ticks_sent++;
        end
        if (!s_tvalid || s_tready) begin
            if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= {7'd0, ticks_to_send.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and result check
    always @(posedge clk) begin
        if (m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", m_tdata));
            end else begin
                want = due_results.pop_front();
                if (m_tdata[7:0] !== want.command)
                    report_mismatch($sformatf("command %h, expected %h",
                                              m_tdata[7:0], want.command));
                if (m_tdata[8] !== want.frame_valid)
                    report_mismatch($sformatf("frame_valid %b, expected %b",
                                              m_tdata[8], want.frame_valid));
                if (m_tdata[9] !== want.led_level)
                    report_mismatch($sformatf("led_level %b, expected %b",
                                              m_tdata[9], want.led_level));
                if (m_tdata[15:10] !== 6'd0)
                    report_mismatch($sformatf("padding bits %b not zero", m_tdata[15:10]));
            end
            words_seen++;
        end
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_cnt, due_results.size());
            $display("[ir_pulse_distance_decoder_top] ERROR");
            $finish;
        end
    end

    task automatic put(input bit b);
        ticks_to_send.push_back(b);
        ticks_queued++;
    endtask

    // quiet ticks, then an edge that measures iv
    task automatic push_interval(input int iv);
        repeat (iv - 1)
            put(1'b0);
        put(1'b1);
    endtask

    task automatic push_close();
        repeat ((cfg_tmo == 0) ? 1 : cfg_tmo)
            put(1'b0);
    endtask

    function automatic int bit_interval(input logic one);
        if (one)
            return $urandom_range(cfg_one_hi, (cfg_one_lo == 0) ? 1 : cfg_one_lo);
        if (cfg_one_lo > 1 && $urandom_range(1) == 1)
            return $urandom_range(cfg_one_lo - 1, 1);
        return cfg_one_hi + $urandom_range(3, 1);
    endfunction

    // sender idle until every tick is taken and every result is back
    task automatic settle();
        do
            @(negedge clk);
        while (ticks_to_send.size() != 0 || s_tvalid || due_results.size() != 0);
        repeat (6) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_TIMEOUT:   cfg_tmo     = val;
            REG_LEAD_MIN:  cfg_lead_lo = val;
            REG_LEAD_MAX:  cfg_lead_hi = val;
            REG_ONE_MIN:   cfg_one_lo  = val;
            REG_ONE_MAX:   cfg_one_hi  = val;
            REG_FIRST_BIT: cfg_first   = val[IDX_W-1:0];
            REG_ON_CODE:   cfg_on      = val[CMD_W-1:0];
            REG_OFF_CODE:  cfg_off     = val[CMD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_all(input logic [CNT_W-1:0] t, input logic [CNT_W-1:0] llo,
                           input logic [CNT_W-1:0] lhi, input logic [CNT_W-1:0] olo,
                           input logic [CNT_W-1:0] ohi, input logic [IDX_W-1:0] fb,
                           input logic [CMD_W-1:0] on_c, input logic [CMD_W-1:0] off_c);
        write_reg(REG_TIMEOUT, t);
        write_reg(REG_LEAD_MIN, llo);
        write_reg(REG_LEAD_MAX, lhi);
        write_reg(REG_ONE_MIN, olo);
        write_reg(REG_ONE_MAX, ohi);
        write_reg(REG_FIRST_BIT, CNT_W'(fb));
        write_reg(REG_ON_CODE, CNT_W'(on_c));
        write_reg(REG_OFF_CODE, CNT_W'(off_c));
        end_writes();
        settings_used++;
    endtask

    task automatic random_settings();
        logic [CNT_W-1:0] t, llo, lhi, olo, ohi;
        logic [IDX_W-1:0] fb;
        logic [CMD_W-1:0] on_c, off_c;
        int               r;
        llo = ($urandom_range(9) == 0) ? '0 : CNT_W'($urandom_range(9, 5));
        lhi = llo + CNT_W'($urandom_range(3)) + ((llo == 0) ? CNT_W'(5) : '0);
        olo = ($urandom_range(9) == 0) ? '0 : CNT_W'($urandom_range(4, 1));
        ohi = olo + CNT_W'($urandom_range(2)) + ((olo == 0) ? CNT_W'(1) : '0);
        r = $urandom_range(19);
        if (r == 0)
            fb = '0;
        else if (r == 1)
            fb = IDX_W'($urandom_range(42, 4));
        else if (r == 2)
            fb = 6'd63;
        else
            fb = IDX_W'($urandom_range(3, 1));
        on_c  = CMD_W'($urandom);
        off_c = ($urandom_range(7) == 0) ? on_c : CMD_W'($urandom);
        // a short timeout now and then breaks frames in the middle
        t = ($urandom_range(7) == 0) ? CNT_W'($urandom_range(8, 2))
                                     : CNT_W'($urandom_range(30, 14));
        set_all(t, llo, lhi, olo, ohi, fb, on_c, off_c);
    endtask

    task automatic queue_random_frame();
        int               kind, last, i;
        logic [CMD_W-1:0] cmd;
        kind = $urandom_range(99);
        frames_queued++;
        put(1'b1);
        if (kind < 6) begin
            // line noise, edges at random spacing
            repeat ($urandom_range(60, 10))
                put($urandom_range(3) == 0);
        end else if (kind >= 12) begin
            case ($urandom_range(2))
                0:       cmd = cfg_on;
                1:       cmd = cfg_off;
                default: cmd = CMD_W'($urandom);
            endcase
            if (kind < 84)
                push_interval($urandom_range(cfg_lead_hi, (cfg_lead_lo == 0) ? 1 : cfg_lead_lo));
            else if (kind < 92)
                push_interval(cfg_lead_hi + 1);
            else
                push_interval((cfg_lead_lo > 1) ? cfg_lead_lo - 1 : cfg_lead_hi + 2);
            last = cfg_first + 7 + $urandom_range(2);
            if (kind >= 76 && kind < 84)
                last = $urandom_range(last, 1);
            if (last > 55)
                last = 55;
            for (i = 1; i <= last; i++) begin
                if (i >= cfg_first && i - cfg_first < 8)
                    push_interval(bit_interval(cmd[i - cfg_first]));
                else
                    push_interval($urandom_range(cfg_one_hi + 3, 1));
            end
        end
        push_close();
    endtask

    initial begin
        int ph, grp, tick_goal, frame_goal;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 23;
        recv_idle_pct = 51;

        set_all(6, 3, 4, 2, 2, 1, 8'hFF, 8'h00);
        // all-ones command with the leader at its low limit turns the led on
        put(1'b1);
        push_interval(3);
        repeat (8) push_interval(2);
        push_close();
        // leader just past the window: invalid frame
        put(1'b1);
        push_interval(5);
        repeat (8) push_interval(1);
        push_close();
        // short frame at the high leader limit, upper bits stay from before
        put(1'b1);
        push_interval(4);
        push_interval(1);
        push_interval(1);
        push_interval(2);
        push_close();
        // all-zero command turns the led off
        put(1'b1);
        push_interval(3);
        repeat (8) push_interval(1);
        push_close();
        // lone edge, no leader measured
        put(1'b1);
        push_close();
        // edge right at the timeout ends the frame and opens the next
        put(1'b1);
        push_interval(3);
        push_interval(6);
        push_close();
        settle();

        // zero timeout closes on the next tick; on and off codes equal
        set_all(0, 0, 24'hFFFFFF, 0, 1, 0, 8'h01, 8'h01);
        put(1'b1);
        put(1'b1);
        put(1'b0);
        settle();

        // leader interval doubles as command bit zero
        set_all(10, 0, 24'hFFFFFF, 3, 3, 0, 8'h02, 8'h03);
        put(1'b1);
        push_interval(3);
        push_interval(3);
        push_interval(1);
        push_close();
        settle();

        // back-to-back edges past the interval limit
        set_all(4, 1, 1, 1, 1, 42, 8'hFF, 8'h80);
        repeat (56) put(1'b1);
        push_close();
        settle();
        set_all(4, 1, 1, 1, 1, 63, 8'h00, 8'hFF);
        put(1'b1);
        push_interval(1);
        push_close();
        settle();

        // longest timeout, then shortened while the frame is still open
        write_reg(REG_TIMEOUT, 24'hFFFFFF);
        end_writes();
        put(1'b1);
        push_interval(1);
        put(1'b0);
        put(1'b0);
        settle();
        write_reg(REG_TIMEOUT, 1);
        end_writes();
        put(1'b0);
        settle();

        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 51 : 0;
            recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 23 : 0;
            tick_goal  = ticks_queued + 160;
            frame_goal = frames_queued + 2;
            grp = 0;
            while (ticks_queued < tick_goal || frames_queued < frame_goal) begin
                random_settings();
                repeat ((ph == 0 && grp == 0) ? 4 : $urandom_range(4, 2))
                    queue_random_frame();
                // long receiver hold while ticks keep coming, input backs up
                if (ph == 0 && grp == 0)
                    stall_left = HOLD_CYCLES;
                settle();
                grp++;
            end
        end

        repeat (10) @(posedge clk);
        $display("%0d ticks sent under %0d decoder settings, %0d result words checked",
                 ticks_sent, settings_used, words_seen);
        $display("frames ranged over valid, broken, noisy and overlong, with swapped idling");
        if (mismatches == 0)
            $display("[ir_pulse_distance_decoder_top] OK");
        else
            $display("[ir_pulse_distance_decoder_top] ERROR");
        $finish;
    end

endmodule
